>>> src/quad_tangent_bitangent_assert.svh
// Assertion macros for the quad tangent/bitangent block.
`ifndef QUAD_TANGENT_BITANGENT_ASSERT_SVH
`define QUAD_TANGENT_BITANGENT_ASSERT_SVH
`ifndef ASSERT_OFF
`define QTB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qtb assertion failed");
`define QTB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("qtb reset check failed");
`else
`define QTB_ASSERT(lbl, prop)
`define QTB_ASSERT_RST(lbl, prop)
`endif
`endif

>>> src/qtb_pkg.sv
// Types, constants and neighbor tables shared by the tangent frame block.
package qtb_pkg;

    localparam int unsigned VERTS = 4;

    localparam logic [1:0] LAST_SLOT = 2'd3;
    localparam logic [4:0] MUL_LAST  = 5'd13;
    localparam logic [4:0] SQ_LAST   = 5'd2;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd15;
    localparam logic [1:0] COMP_LAST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_K, S_RD_A, S_RD_B, S_EDGE, S_MUL,
        S_PREP, S_SQ, S_SQRT, S_DIV, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_WRITE, OP_RD_K, OP_RD_A, OP_RD_B, OP_EDGE, OP_MUL,
        OP_PREP, OP_SQ, OP_SQRT, OP_DIV, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] addr;
        logic [4:0] cnt;
        logic [1:0] comp;
        logic       vsel;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic vec_zero;
        logic out_free;
    } t_sts;

    function automatic logic [1:0] nbr_a(input logic [1:0] k);
        logic [1:0] r;
        unique case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            2'd2:    r = 2'd1;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nbr_b(input logic [1:0] k);
        logic [1:0] r;
        unique case (k)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

>>> src/qtb_ctrl.sv
// Sequencer for vertex intake and per-vertex frame computation.
module qtb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qtb_pkg::t_sts i_sts,
    output qtb_pkg::t_cmd o_cmd
);

    qtb_pkg::t_state r_state, n_state;
    logic [1:0] r_slot, n_slot;
    logic [1:0] r_k, n_k;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;
    logic       r_vsel, n_vsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qtb_pkg::S_IDLE;
            r_slot  <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_vsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
            r_vsel  <= n_vsel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        n_vsel  = r_vsel;
        unique case (r_state)
            qtb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_slot = r_slot + 2'd1;
                    if (r_slot == qtb_pkg::LAST_SLOT) begin
                        n_state = qtb_pkg::S_RD_K;
                        n_k     = '0;
                    end
                end
            end
            qtb_pkg::S_RD_K: n_state = qtb_pkg::S_RD_A;
            qtb_pkg::S_RD_A: n_state = qtb_pkg::S_RD_B;
            qtb_pkg::S_RD_B: n_state = qtb_pkg::S_EDGE;
            qtb_pkg::S_EDGE: begin
                n_state = qtb_pkg::S_MUL;
                n_cnt   = '0;
            end
            qtb_pkg::S_MUL: begin
                if (r_cnt == qtb_pkg::MUL_LAST) begin
                    n_state = qtb_pkg::S_PREP;
                    n_vsel  = 1'b0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            qtb_pkg::S_PREP: begin
                n_cnt = '0;
                if (i_sts.det_zero || i_sts.vec_zero) n_state = qtb_pkg::S_EMIT;
                else n_state = qtb_pkg::S_SQ;
            end
            qtb_pkg::S_SQ: begin
                if (r_cnt == qtb_pkg::SQ_LAST) begin
                    n_state = qtb_pkg::S_SQRT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            qtb_pkg::S_SQRT: begin
                if (r_cnt == qtb_pkg::SQRT_LAST) begin
                    n_state = qtb_pkg::S_DIV;
                    n_cnt   = '0;
                    n_comp  = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            qtb_pkg::S_DIV: begin
                if (r_cnt == qtb_pkg::DIV_LAST) begin
                    n_cnt = '0;
                    if (r_comp == qtb_pkg::COMP_LAST) begin
                        if (!r_vsel) begin
                            n_state = qtb_pkg::S_PREP;
                            n_vsel  = 1'b1;
                        end else begin
                            n_state = qtb_pkg::S_EMIT;
                        end
                    end else begin
                        n_comp = r_comp + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            qtb_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    if (r_k == qtb_pkg::LAST_SLOT) begin
                        n_state = qtb_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = qtb_pkg::S_RD_K;
                    end
                end
            end
            default: n_state = qtb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = qtb_pkg::OP_NONE;
        o_cmd.addr = r_k;
        o_cmd.cnt  = r_cnt;
        o_cmd.comp = r_comp;
        o_cmd.vsel = r_vsel;
        o_cmd.last = (r_k == qtb_pkg::LAST_SLOT);
        unique case (r_state)
            qtb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.addr = r_slot;
                if (i_in_valid) o_cmd.op = qtb_pkg::OP_WRITE;
            end
            qtb_pkg::S_RD_K: o_cmd.op = qtb_pkg::OP_RD_K;
            qtb_pkg::S_RD_A: begin
                o_cmd.op   = qtb_pkg::OP_RD_A;
                o_cmd.addr = qtb_pkg::nbr_a(r_k);
            end
            qtb_pkg::S_RD_B: begin
                o_cmd.op   = qtb_pkg::OP_RD_B;
                o_cmd.addr = qtb_pkg::nbr_b(r_k);
            end
            qtb_pkg::S_EDGE: o_cmd.op = qtb_pkg::OP_EDGE;
            qtb_pkg::S_MUL:  o_cmd.op = qtb_pkg::OP_MUL;
            qtb_pkg::S_PREP: o_cmd.op = qtb_pkg::OP_PREP;
            qtb_pkg::S_SQ:   o_cmd.op = qtb_pkg::OP_SQ;
            qtb_pkg::S_SQRT: o_cmd.op = qtb_pkg::OP_SQRT;
            qtb_pkg::S_DIV:  o_cmd.op = qtb_pkg::OP_DIV;
            qtb_pkg::S_EMIT: o_cmd.op = qtb_pkg::OP_EMIT;
            default:         o_cmd.op = qtb_pkg::OP_NONE;
        endcase
    end

endmodule

>>> src/qtb_dpath.sv
// Face store, shared multiplier, root and divide unit, and result register.
module qtb_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qtb_pkg::t_cmd i_cmd,
    output qtb_pkg::t_sts o_sts,
    input  logic [79:0]   i_in_data,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [95:0]   o_out_data,
    output logic          o_out_degen,
    output logic          o_out_last
);

    function automatic logic signed [16:0] sdiff(input logic [15:0] a, input logic [15:0] b);
        return $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    function automatic logic signed [16:0] udiff(input logic [15:0] a, input logic [15:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // face store: one write or one registered read per cycle
    logic [47:0] r_mem_pos [qtb_pkg::VERTS];
    logic [31:0] r_mem_uv  [qtb_pkg::VERTS];
    logic [47:0] r_rd_pos;
    logic [31:0] r_rd_uv;
    logic [47:0] r_base_pos;
    logic [31:0] r_base_uv;

    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    logic signed [16:0] r_du1, r_dv1, r_du2, r_dv2;

    // slot 0 det, 1..3 tangent, 4..6 bitangent
    logic signed [34:0] r_vec [7];
    logic signed [34:0] r_acc;

    logic [29:0] r_mag [3];
    logic        r_neg [3];
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [44:0] r_rem;
    logic [13:0] r_q;
    logic [15:0] r_tan [3];
    logic [15:0] r_btn [3];
    logic        r_fail;
    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic        r_out_degen;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == qtb_pkg::OP_WRITE) begin
            r_mem_pos[i_cmd.addr] <= i_in_data[47:0];
            r_mem_uv[i_cmd.addr]  <= i_in_data[79:48];
        end
        r_rd_pos <= r_mem_pos[i_cmd.addr];
        r_rd_uv  <= r_mem_uv[i_cmd.addr];
    end

    // multiplier operand select
    logic [2:0]         w_pair;
    logic               w_odd;
    logic signed [16:0] w_ma, w_mb;
    logic signed [33:0] w_prod;

    assign w_pair = i_cmd.cnt[3:1];
    assign w_odd  = i_cmd.cnt[0];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (w_pair)
            3'd0: begin w_ma = w_odd ? r_dv1 : r_du1; w_mb = w_odd ? r_du2 : r_dv2; end
            3'd1: begin w_ma = w_odd ? r_dv1 : r_dv2; w_mb = w_odd ? r_e2[0] : r_e1[0]; end
            3'd2: begin w_ma = w_odd ? r_dv1 : r_dv2; w_mb = w_odd ? r_e2[1] : r_e1[1]; end
            3'd3: begin w_ma = w_odd ? r_dv1 : r_dv2; w_mb = w_odd ? r_e2[2] : r_e1[2]; end
            3'd4: begin w_ma = w_odd ? r_du2 : r_du1; w_mb = w_odd ? r_e1[0] : r_e2[0]; end
            3'd5: begin w_ma = w_odd ? r_du2 : r_du1; w_mb = w_odd ? r_e1[1] : r_e2[1]; end
            3'd6: begin w_ma = w_odd ? r_du2 : r_du1; w_mb = w_odd ? r_e1[2] : r_e2[2]; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // normalization front end
    logic signed [34:0] w_v [3];
    logic [33:0]        w_vmag [3];
    logic               w_vneg [3];
    logic [33:0]        w_max;
    logic [2:0]         w_shift;
    logic               w_det_zero;

    assign w_det_zero = (r_vec[0] == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i]    = i_cmd.vsel ? r_vec[4 + i] : r_vec[1 + i];
            w_vmag[i] = w_v[i][34] ? 34'(-w_v[i]) : w_v[i][33:0];
            w_vneg[i] = w_v[i][34] ^ r_vec[0][34];
        end
        w_max = w_vmag[0];
        if (w_vmag[1] > w_max) w_max = w_vmag[1];
        if (w_vmag[2] > w_max) w_max = w_vmag[2];
        priority if (w_max[33]) w_shift = 3'd4;
        else if (w_max[32])     w_shift = 3'd3;
        else if (w_max[31])     w_shift = 3'd2;
        else if (w_max[30])     w_shift = 3'd1;
        else                    w_shift = 3'd0;
    end

    // sum of squares
    logic [29:0] w_sqin;
    logic [59:0] w_sq;
    assign w_sqin = r_mag[i_cmd.cnt[1:0]];
    assign w_sq   = w_sqin * w_sqin;

    // square root, two bits of radicand per step
    logic [5:0]  w_bpos;
    logic [63:0] w_bit;
    logic [63:0] w_trial;
    assign w_bpos  = 6'd62 - {i_cmd.cnt, 1'b0};
    assign w_bit   = 64'd1 << w_bpos;
    assign w_trial = r_res + w_bit;

    // restoring divide, one quotient bit per step
    logic [30:0] w_root;
    logic [45:0] w_dsh;
    logic        w_ge;
    logic [14:0] w_qn;
    logic [15:0] w_qs;
    assign w_root = r_res[30:0];
    assign w_dsh  = 46'(w_root) << (4'd15 - i_cmd.cnt[3:0]);
    assign w_ge   = ({1'b0, r_rem} >= w_dsh);
    assign w_qn   = {r_q, w_ge};
    assign w_qs   = r_neg[i_cmd.comp] ? 16'(-{1'b0, w_qn}) : {1'b0, w_qn};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            qtb_pkg::OP_RD_A: begin
                r_base_pos <= r_rd_pos;
                r_base_uv  <= r_rd_uv;
            end
            qtb_pkg::OP_RD_B: begin
                for (int i = 0; i < 3; i++)
                    r_e1[i] <= sdiff(r_rd_pos[16*i +: 16], r_base_pos[16*i +: 16]);
                r_du1 <= udiff(r_rd_uv[15:0], r_base_uv[15:0]);
                r_dv1 <= udiff(r_rd_uv[31:16], r_base_uv[31:16]);
            end
            qtb_pkg::OP_EDGE: begin
                for (int i = 0; i < 3; i++)
                    r_e2[i] <= sdiff(r_rd_pos[16*i +: 16], r_base_pos[16*i +: 16]);
                r_du2 <= udiff(r_rd_uv[15:0], r_base_uv[15:0]);
                r_dv2 <= udiff(r_rd_uv[31:16], r_base_uv[31:16]);
            end
            qtb_pkg::OP_MUL: begin
                if (!w_odd) r_acc <= 35'(w_prod);
                else r_vec[w_pair] <= r_acc - 35'(w_prod);
            end
            qtb_pkg::OP_PREP: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= 30'(w_vmag[i] >> w_shift);
                    r_neg[i] <= w_vneg[i];
                end
            end
            qtb_pkg::OP_SQ: begin
                r_n   <= (i_cmd.cnt == '0) ? 64'(w_sq) : r_n + 64'(w_sq);
                r_res <= '0;
            end
            qtb_pkg::OP_SQRT: begin
                if (r_n >= w_trial) begin
                    r_n   <= r_n - w_trial;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            qtb_pkg::OP_DIV: begin
                if (i_cmd.cnt == '0) begin
                    r_rem <= {1'b0, r_mag[i_cmd.comp], 14'd0} + 45'(w_root >> 1);
                    r_q   <= '0;
                end else begin
                    if (w_ge) r_rem <= 45'({1'b0, r_rem} - w_dsh);
                    r_q <= w_qn[13:0];
                    if (i_cmd.cnt == qtb_pkg::DIV_LAST) begin
                        if (i_cmd.vsel) r_btn[i_cmd.comp] <= w_qs;
                        else r_tan[i_cmd.comp] <= w_qs;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else if (i_cmd.op == qtb_pkg::OP_RD_K) begin
            r_fail <= 1'b0;
        end else if (i_cmd.op == qtb_pkg::OP_PREP && (w_det_zero || o_sts.vec_zero)) begin
            r_fail <= 1'b1;
        end
    end

    assign o_sts.det_zero = w_det_zero;
    assign o_sts.vec_zero = (w_max == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == qtb_pkg::OP_EMIT && o_sts.out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == qtb_pkg::OP_EMIT && o_sts.out_free) begin
            r_out_data  <= r_fail ? '0 : {r_btn[2], r_btn[1], r_btn[0],
                                          r_tan[2], r_tan[1], r_tan[0]};
            r_out_degen <= r_fail;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_degen = r_out_degen;
    assign o_out_last  = r_out_last;

endmodule

>>> src/quad_tangent_bitangent.sv
// Top level of the quad face tangent/bitangent unit.
// Vertices of a quad face arrive one item per cycle while the unit is idle, four per face;
// the first three are only stored. The fourth starts the frame computation and input stays
// stalled until it ends. Each of the four vertices takes three store reads and an edge
// step, fourteen steps of one shared 17x17 multiplier, then for tangent and bitangent each
// a setup step, a sum of squares over three terms, a 32-step square root and three 16-step
// divides, and an emit step. A degenerate vertex ends early. Results leave through an
// output register, so the next face may start while the last result still waits.
`include "quad_tangent_bitangent_assert.svh"

module quad_tangent_bitangent (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z
    output logic [95:0] o_m_tdata,
    // degenerate
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    qtb_pkg::t_cmd w_cmd;
    qtb_pkg::t_sts w_sts;

    qtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qtb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_degen (o_m_tuser),
        .o_out_last  (o_m_tlast)
    );

    `QTB_ASSERT(a_no_work_while_ready, o_s_tready |-> (w_cmd.op == qtb_pkg::OP_WRITE || w_cmd.op == qtb_pkg::OP_NONE))
    `QTB_ASSERT(a_degen_zero, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
    `QTB_ASSERT_RST(a_reset_idle, !i_rst_n |=> (o_s_tready && !o_m_tvalid))

endmodule
